// ----- sv/crc8cfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8cfc_pkg
// Shared constants, result type and CRC-8 byte update for the command frame
// checker.
// ----------------------------------------------------------------------------
package crc8cfc_pkg;

   // Frame layout: three payload bytes followed by one check byte
   localparam int unsigned FRAME_BYTES = 4;
   localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_FIRST = '0;
   localparam logic [POS_W-1:0] POS_GAIN_HI = POS_W'(0);
   localparam logic [POS_W-1:0] POS_GAIN_LO = POS_W'(1);
   localparam logic [POS_W-1:0] POS_SCAN    = POS_W'(2);
   localparam logic [POS_W-1:0] POS_CHECK   = POS_W'(FRAME_BYTES - 1);

   // CRC-8, polynomial 0x31, MSB first, no final XOR
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Reply codes
   localparam logic [1:0] REPLY_ERR = 2'd1;
   localparam logic [1:0] REPLY_OK  = 2'd2;

   // Output tdata width, padded to whole bytes
   localparam int unsigned RSP_FIELD_W = 2 + 16 + 8;
   localparam int unsigned RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef struct packed {
      logic [1:0]  reply_byte;
      logic        frame_valid;
      logic [15:0] gain_word;
      logic [7:0]  scan_time;
   } result_type;

   // Fold one byte into the running CRC, one bit per step
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- sv/crc8cfc_assembler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8cfc_assembler
// Tracks the byte position in the frame, keeps the running CRC and the payload
// bytes, and builds the result when the check byte arrives.
// ----------------------------------------------------------------------------
module crc8cfc_assembler
   import crc8cfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_accept,
   input  logic [7:0]  byte_data,
   output logic        at_check,
   output logic        result_load,
   output result_type  result
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       crc_ff, crc_in;
   logic [7:0]       gain_hi_ff, gain_hi_in;
   logic [7:0]       gain_lo_ff, gain_lo_in;
   logic [7:0]       scan_ff, scan_in;
   logic             crc_match;

   assign at_check    = (pos_ff == POS_CHECK);
   assign result_load = byte_accept && at_check;
   assign crc_match   = (byte_data == crc_ff);

   // Build the result for the check byte
   always_comb begin
      if (crc_match) begin
         result.reply_byte  = REPLY_OK;
         result.frame_valid = 1'b1;
         result.gain_word   = {gain_hi_ff, gain_lo_ff};
         result.scan_time   = scan_ff;
      end else begin
         result.reply_byte  = REPLY_ERR;
         result.frame_valid = 1'b0;
         result.gain_word   = '0;
         result.scan_time   = '0;
      end
   end

   // Advance position and CRC, capture payload bytes
   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      gain_hi_in = gain_hi_ff;
      gain_lo_in = gain_lo_ff;
      scan_in    = scan_ff;
      if (byte_accept) begin
         if (at_check) begin
            pos_in = POS_FIRST;
            crc_in = CRC_INIT;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            crc_in = crc8_update(crc_ff, byte_data);
            unique case (pos_ff)
               POS_GAIN_HI: gain_hi_in = byte_data;
               POS_GAIN_LO: gain_lo_in = byte_data;
               default:     scan_in    = byte_data;
            endcase
         end
      end
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_FIRST;
         crc_ff <= CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   // Payload bytes need no reset
   always_ff @(posedge clock) begin
      gain_hi_ff <= gain_hi_in;
      gain_lo_ff <= gain_lo_in;
      scan_ff    <= scan_in;
   end

endmodule

// ----- sv/crc8cfc_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8cfc_out_reg
// Result register: holds one finished item until the downstream side takes it.
// ----------------------------------------------------------------------------
module crc8cfc_out_reg
   import crc8cfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       take,
   output logic       full,
   output result_type data
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // Load a new item, drop a taken one, otherwise hold
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign full = valid_ff;
   assign data = data_ff;

endmodule

// ----- sv/crc8_command_frame_checker_core.sv -----
`timescale 1ns / 1ps
// A result item appears in the cycle after the frame's check byte is accepted.
// Throughput: one byte per cycle; bytes 0 to 2 are always taken at once, the check
// byte waits only while a previous result sits unread in the result register.
// Reset: synchronous, clears the byte position to zero, the CRC to 0xFF and the
// result register's valid flag.
// ----------------------------------------------------------------------------
// crc8_command_frame_checker_core
// Collects four-byte command frames, checks the CRC-8 trailer and answers
// with the gain word and scan time or a checksum error.
// ----------------------------------------------------------------------------
module crc8_command_frame_checker_core
   import crc8cfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [1:0] reply_byte, [17:2] gain_word,
                                             // [25:18] scan_time, rest zero
   output logic                  rsp_tuser   // [0] frame_valid
);

   logic       byte_accept;
   logic       at_check;
   logic       result_load;
   logic       out_full;
   result_type result;
   result_type out_data;

   // Take payload bytes always, the check byte when the result slot frees up
   assign req_tready  = !at_check || !out_full || rsp_tready;
   assign byte_accept = req_tvalid && req_tready;

   crc8cfc_assembler u_assembler (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .byte_data   (req_tdata),
      .at_check    (at_check),
      .result_load (result_load),
      .result      (result)
   );

   crc8cfc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (result_load),
      .load_data (result),
      .take      (rsp_tready),
      .full      (out_full),
      .data      (out_data)
   );

   // Pack the result fields, lowest field first
   assign rsp_tvalid = out_full;
   assign rsp_tuser  = out_data.frame_valid;
   assign rsp_tdata  = RSP_DATA_W'({out_data.scan_time, out_data.gain_word,
                                    out_data.reply_byte});

endmodule

// ----- sv/crc8cfc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8cfc_checker
// Port-level checks on the command frame checker's result stream.
// ----------------------------------------------------------------------------
module crc8cfc_checker
   import crc8cfc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // Reply code agrees with frame_valid; an error carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser && rsp_tdata[1:0] == REPLY_OK) ||
                     (!rsp_tuser && rsp_tdata[1:0] == REPLY_ERR && rsp_tdata[25:2] == '0))
      else $error("reply code and frame_valid disagree");

   // No result right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result item valid after reset");

   // A fresh result follows an accepted input byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && !$past(reset) |-> $past(req_tvalid && req_tready))
      else $error("result item appeared without an accepted byte");

endmodule

bind crc8_command_frame_checker_core crc8cfc_checker u_crc8cfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
